[rtl/core/ocg_pkg.sv]
`default_nettype none

package ocg_pkg;

  // fixed field widths
  localparam int COORD_W  = 8;
  localparam int FUNC_W   = 2;
  localparam int CFG_W    = 16;
  localparam int DIM_W    = 9;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 10;
  localparam int VAL_W    = 16;
  localparam int CLASS_W  = 2;
  localparam int CFG_IDX_W = 4;

  // stream payload widths
  localparam int S_TDATA_W = 32;
  localparam int S_TUSER_W = FUNC_W;
  localparam int M_TDATA_W = 32;

  // default sizes
  localparam int DEF_GRID_DIM     = 256;
  localparam int DEF_LOGODDS_BITS = 16;
  localparam int DEF_STEP_LIMIT   = 1000;

  // register reset values, Q8.8 where signed
  localparam logic signed [CFG_W-1:0] RST_HIT_INC   = 16'sd217;
  localparam logic signed [CFG_W-1:0] RST_MISS_INC  = -16'sd104;
  localparam logic signed [CFG_W-1:0] RST_CLAMP_LO  = -16'sd1024;
  localparam logic signed [CFG_W-1:0] RST_CLAMP_HI  = 16'sd1024;
  localparam logic        [DIM_W-1:0] RST_WIDTH     = 9'd256;
  localparam logic        [DIM_W-1:0] RST_HEIGHT    = 9'd256;
  localparam logic signed [CFG_W-1:0] RST_FREE_THR  = -16'sd281;
  localparam logic signed [CFG_W-1:0] RST_OCC_THR   = 16'sd158;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIT_INC  = 4'd0,
    CFG_MISS_INC = 4'd1,
    CFG_CLAMP_LO = 4'd2,
    CFG_CLAMP_HI = 4'd3,
    CFG_WIDTH    = 4'd4,
    CFG_HEIGHT   = 4'd5,
    CFG_FREE_THR = 4'd6,
    CFG_OCC_THR  = 4'd7
  } cfg_idx_t;

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_RAY   = 2'd0,
    FN_READ  = 2'd1,
    FN_CLEAR = 2'd2,
    FN_NONE  = 2'd3
  } func_t;

  // result status codes
  localparam logic [STATUS_W-1:0] STS_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] STS_REJECTED = 2'd1;
  localparam logic [STATUS_W-1:0] STS_TRUNC    = 2'd2;

  // cell class codes
  localparam logic [CLASS_W-1:0] CLS_FREE    = 2'd0;
  localparam logic [CLASS_W-1:0] CLS_OCC     = 2'd1;
  localparam logic [CLASS_W-1:0] CLS_UNKNOWN = 2'd2;
  localparam logic [CLASS_W-1:0] CLS_NONE    = 2'd0;

endpackage

`default_nettype wire

[rtl/core/occupancy_grid_ray_update.sv]
// ray: each visited cell is read, added to, clamped and written back, one cell after
//   another, at most max(|dx|,|dy|)+1 cells in all; one RAM port sets the pace
// read: one RAM read, then the cell is classified for the result transaction; out-of-grid read: no RAM access
// clear: the whole grid is zeroed, one cell per cycle
// one operation at a time; the result register frees the input side early
// reset: synchronous; a clearing pass over all GRID_DIM*GRID_DIM cells zeroes the grid
`default_nettype none

module occupancy_grid_ray_update #(
  parameter int GRID_DIM     = ocg_pkg::DEF_GRID_DIM,
  parameter int LOGODDS_BITS = ocg_pkg::DEF_LOGODDS_BITS,
  parameter int STEP_LIMIT   = ocg_pkg::DEF_STEP_LIMIT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // start_x, start_y, end_x, end_y
  input  logic [ocg_pkg::S_TDATA_W-1:0]  s_tdata,
  // func
  input  logic [ocg_pkg::S_TUSER_W-1:0]  s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // status, cells_updated, cell_log_odds, cell_class, zero fill
  output logic [ocg_pkg::M_TDATA_W-1:0]  m_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ocg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ocg_pkg::CFG_W-1:0]      cfg_data
);

  import ocg_pkg::*;

  localparam int DEPTH  = GRID_DIM * GRID_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LB     = LOGODDS_BITS;
  localparam int SUM_W  = ((LB > CFG_W) ? LB : CFG_W) + 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic signed [SUM_W-1:0] SMAX = SUM_W'((longint'(1) <<< (LB - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SMIN = SUM_W'(-(longint'(1) <<< (LB - 1)));

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_READ  = 7'b0000100,
    ST_SUM   = 7'b0001000,
    ST_WRITE = 7'b0010000,
    ST_CLASS = 7'b0100000,
    ST_RESP  = 7'b1000000
  } state_t;

  state_t state;

  // configuration registers
  logic signed [CFG_W-1:0] hit_inc, miss_inc, clamp_lo, clamp_hi, free_thr, occ_thr;
  logic        [DIM_W-1:0] grid_width, grid_height;

  // input fields
  func_t              in_func;
  logic [COORD_W-1:0] in_x0, in_y0, in_x1, in_y1;
  logic               start_ok, end_ok, item_acc;

  // operation held for the walk
  func_t in_func_q;

  // walk state
  logic [COORD_W-1:0]      cur_x, cur_y, end_x, end_y, dx, dy;
  logic                    sx, sy;
  logic signed [10:0]      err;
  logic [8:0]              nx, ny;
  logic                    at_end;
  logic signed [11:0]      e2;
  logic                    step_x, step_y, trunc;
  logic signed [10:0]      err_next;
  logic [COORD_W-1:0]      x_next, y_next;
  logic [8:0]              nx_next, ny_next;

  // cell arithmetic
  logic signed [SUM_W-1:0] sum, rd_ext, lo_ext, hi_ext, v_lo, v_hi, v_sat;

  // memory port
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_addr, cell_addr, clr_addr;
  logic [LB-1:0]        ram_wdata, ram_rdata;
  logic                 clr_resp;

  // result
  logic [STATUS_W-1:0]  res_status;
  logic [COUNT_W-1:0]   res_count;
  logic [VAL_W-1:0]     res_val;
  logic [CLASS_W-1:0]   res_class;
  logic                 out_free;

  // input unpacking
  assign in_func  = func_t'(s_tuser);
  assign in_x0    = s_tdata[7:0];
  assign in_y0    = s_tdata[15:8];
  assign in_x1    = s_tdata[23:16];
  assign in_y1    = s_tdata[31:24];
  assign item_acc = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  // grid bounds, size register limited to GRID_DIM
  assign start_ok = ({1'b0, in_x0} < grid_width) && (int'(in_x0) < GRID_DIM) &&
                    ({1'b0, in_y0} < grid_height) && (int'(in_y0) < GRID_DIM);
  assign end_ok   = ({1'b0, in_x1} < grid_width) && (int'(in_x1) < GRID_DIM) &&
                    ({1'b0, in_y1} < grid_height) && (int'(in_y1) < GRID_DIM);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_inc     <= RST_HIT_INC;
      miss_inc    <= RST_MISS_INC;
      clamp_lo    <= RST_CLAMP_LO;
      clamp_hi    <= RST_CLAMP_HI;
      grid_width  <= RST_WIDTH;
      grid_height <= RST_HEIGHT;
      free_thr    <= RST_FREE_THR;
      occ_thr     <= RST_OCC_THR;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_HIT_INC:  hit_inc     <= cfg_data;
        CFG_MISS_INC: miss_inc    <= cfg_data;
        CFG_CLAMP_LO: clamp_lo    <= cfg_data;
        CFG_CLAMP_HI: clamp_hi    <= cfg_data;
        CFG_WIDTH:    grid_width  <= cfg_data[DIM_W-1:0];
        CFG_HEIGHT:   grid_height <= cfg_data[DIM_W-1:0];
        CFG_FREE_THR: free_thr    <= cfg_data;
        CFG_OCC_THR:  occ_thr     <= cfg_data;
        default: ;
      endcase
    end
  end

  // bresenham step
  assign at_end   = (cur_x == end_x) && (cur_y == end_y);
  assign e2       = {err, 1'b0};
  assign step_x   = e2 > -$signed({4'b0, dy});
  assign step_y   = e2 < $signed({4'b0, dx});
  assign err_next = err - (step_x ? $signed({3'b0, dy}) : 11'sd0)
                        + (step_y ? $signed({3'b0, dx}) : 11'sd0);
  assign x_next   = step_x ? (cur_x + (sx ? 8'd1 : 8'd255)) : cur_x;
  assign y_next   = step_y ? (cur_y + (sy ? 8'd1 : 8'd255)) : cur_y;
  assign nx_next  = nx + {8'd0, step_x};
  assign ny_next  = ny + {8'd0, step_y};
  assign trunc    = (int'(nx_next) > STEP_LIMIT) || (int'(ny_next) > STEP_LIMIT);

  // clamp to configured bounds, then to the store width
  assign lo_ext = SUM_W'(clamp_lo);
  assign hi_ext = SUM_W'(clamp_hi);
  assign v_lo   = (sum < lo_ext) ? lo_ext : sum;
  assign v_hi   = (v_lo > hi_ext) ? hi_ext : v_lo;
  assign v_sat  = (v_hi > SMAX) ? SMAX : ((v_hi < SMIN) ? SMIN : v_hi);
  assign rd_ext = SUM_W'($signed(ram_rdata));

  // memory port selection
  assign cell_addr = ADDR_W'(cur_y) * ADDR_W'(GRID_DIM) + ADDR_W'(cur_x);
  assign ram_addr  = (state == ST_CLEAR) ? clr_addr : cell_addr;
  assign ram_we    = (state == ST_CLEAR) || (state == ST_WRITE);
  assign ram_wdata = (state == ST_CLEAR) ? '0 : v_sat[LB-1:0];

  ocg_ram #(
    .WIDTH(LB),
    .DEPTH(DEPTH)
  ) u_log_odds_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // operation sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      clr_resp <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ADDR) begin
            state <= clr_resp ? ST_RESP : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (item_acc) begin
            case (in_func)
              FN_RAY:   state <= (start_ok && end_ok) ? ST_READ : ST_RESP;
              FN_READ:  state <= start_ok ? ST_READ : ST_RESP;
              FN_CLEAR: begin
                state    <= ST_CLEAR;
                clr_addr <= '0;
                clr_resp <= 1'b1;
              end
              default:  state <= ST_RESP;
            endcase
          end
        end
        ST_READ:  state <= (in_func_q == FN_READ) ? ST_CLASS : ST_SUM;
        ST_SUM:   state <= ST_WRITE;
        ST_WRITE: state <= (at_end || trunc) ? ST_RESP : ST_READ;
        ST_CLASS: state <= ST_RESP;
        ST_RESP: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default:  state <= ST_IDLE;
      endcase
    end
  end

  // walk and result datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        in_func_q  <= in_func;
        cur_x      <= in_x0;
        cur_y      <= in_y0;
        end_x      <= in_x1;
        end_y      <= in_y1;
        dx         <= (in_x1 > in_x0) ? (in_x1 - in_x0) : (in_x0 - in_x1);
        dy         <= (in_y1 > in_y0) ? (in_y1 - in_y0) : (in_y0 - in_y1);
        sx         <= in_x0 < in_x1;
        sy         <= in_y0 < in_y1;
        err        <= $signed({3'b0, ((in_x1 > in_x0) ? (in_x1 - in_x0) : (in_x0 - in_x1))})
                    - $signed({3'b0, ((in_y1 > in_y0) ? (in_y1 - in_y0) : (in_y0 - in_y1))});
        nx         <= '0;
        ny         <= '0;
        res_count  <= '0;
        res_val    <= '0;
        res_class  <= (in_func == FN_READ && !start_ok) ? CLS_UNKNOWN : CLS_NONE;
        res_status <= (in_func == FN_RAY && !(start_ok && end_ok)) ? STS_REJECTED : STS_DONE;
      end
      ST_SUM: begin
        sum <= rd_ext + SUM_W'(at_end ? hit_inc : miss_inc);
      end
      ST_WRITE: begin
        res_count <= res_count + 1'b1;
        if (!at_end) begin
          cur_x <= x_next;
          cur_y <= y_next;
          err   <= err_next;
          nx    <= nx_next;
          ny    <= ny_next;
          if (trunc) begin
            res_status <= STS_TRUNC;
          end
        end
      end
      ST_CLASS: begin
        res_val <= rd_ext[VAL_W-1:0];
        if (rd_ext < SUM_W'(free_thr)) begin
          res_class <= CLS_FREE;
        end else if (rd_ext > SUM_W'(occ_thr)) begin
          res_class <= CLS_OCC;
        end else begin
          res_class <= CLS_UNKNOWN;
        end
      end
      default: ;
    endcase
  end

  // output register
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_RESP && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESP && out_free) begin
      m_tdata <= {2'b00, res_class, res_val, res_count, res_status};
    end
  end

  // a result transaction is only ever loaded from the response state
  a_resp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_RESP))
    else $error("result raised outside the response state");

  // the walk never writes a cell outside the configured grid
  a_walk_in_grid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) |-> (({1'b0, cur_x} < grid_width) && ({1'b0, cur_y} < grid_height)))
    else $error("ray walk left the grid");

  // a ray visits at most one cell per column or row spanned
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESP) |-> (res_count <= COUNT_W'(256)))
    else $error("ray cell count out of range");

  // no input transaction while the grid is being cleared
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |=> (!item_acc || $past(clr_addr) == LAST_ADDR))
    else $error("input taken during clearing pass");

endmodule

`default_nettype wire

[rtl/core/ocg_ram.sv]
`default_nettype none

module ocg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

[tb/sv/occupancy_grid_ray_update_tb.sv]
`timescale 1ns / 1ps

module occupancy_grid_ray_update_tb;
  import ocg_pkg::*;

  localparam int GRID        = DEF_GRID_DIM;
  localparam int CYCLE_LIMIT = 5_000_000;
  // settling wait at the end, sized from the longest ray
  localparam int SETTLE_CYCLES = 3 * GRID + 40;
  localparam int SHOWN_MAX   = 10;

  // result field offsets in m_tdata
  localparam int CNT_LSB = STATUS_W;
  localparam int VAL_LSB = CNT_LSB + COUNT_W;
  localparam int CLS_LSB = VAL_LSB + VAL_W;
  localparam int PAD_LSB = CLS_LSB + CLASS_W;

  typedef struct {
    logic [STATUS_W-1:0]     status;
    logic [COUNT_W-1:0]      count;
    logic signed [VAL_W-1:0] val;
    logic [CLASS_W-1:0]      cls;
  } cell_report_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // start_x, start_y, end_x, end_y
  logic [S_TDATA_W-1:0]   s_tdata = '0;
  // func
  logic [S_TUSER_W-1:0]   s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // status, cells_updated, cell_log_odds, cell_class, zero fill
  logic [M_TDATA_W-1:0]   m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  occupancy_grid_ray_update dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mirror of the grid and its registers
  logic signed [VAL_W-1:0] mirror_cells [GRID*GRID];
  logic signed [CFG_W-1:0] hit_inc, miss_inc, clamp_lo, clamp_hi, free_thr, occ_thr;
  logic [DIM_W-1:0]        width_reg, height_reg;

  cell_report_t awaited_reports [$];

  int  cycles = 0;
  int  mismatches = 0;
  int  reports_checked = 0;
  int  n_ops = 0, n_rays = 0, n_rejected = 0, n_reads = 0, n_clears = 0;
  int  burst_left = 0;
  bit  gaps_on = 1'b1;
  int  rx_mode = 0, rx_left = 0;

  function automatic void zero_mirror();
    for (int i = 0; i < GRID * GRID; i++) mirror_cells[i] = '0;
  endfunction

  // size register as used, limited to the grid dimension
  function automatic int used_dim(logic [DIM_W-1:0] r);
    return (int'(r) > GRID) ? GRID : int'(r);
  endfunction

  // add an increment to one cell, clamp low first so the high bound wins
  function automatic void bump_cell(int x, int y, int inc);
    int idx, v;
    idx = y * GRID + x;
    v = int'(mirror_cells[idx]) + inc;
    if (v < int'(clamp_lo)) v = int'(clamp_lo);
    if (v > int'(clamp_hi)) v = int'(clamp_hi);
    mirror_cells[idx] = v[VAL_W-1:0];
  endfunction

  // carry out one operation on the mirror and return its report
  function automatic cell_report_t apply_grid_op(func_t op, int x0, int y0, int x1, int y1);
    cell_report_t r;
    int  w, h, dx, dy, sx, sy, err, e2, x, y;
    bit  walking;
    r = '{STS_DONE, 10'd0, 16'sd0, CLS_NONE};
    w = used_dim(width_reg);
    h = used_dim(height_reg);
    case (op)
      FN_RAY: begin
        if (x0 >= w || y0 >= h || x1 >= w || y1 >= h) begin
          r.status = STS_REJECTED;
        end else begin
          dx = (x1 > x0) ? x1 - x0 : x0 - x1;
          dy = (y1 > y0) ? y1 - y0 : y0 - y1;
          sx = (x0 < x1) ? 1 : -1;
          sy = (y0 < y1) ? 1 : -1;
          err = dx - dy;
          x = x0;
          y = y0;
          walking = 1'b1;
          while (walking) begin
            if (x == x1 && y == y1) begin
              bump_cell(x, y, int'(hit_inc));
              r.count = r.count + 1'b1;
              walking = 1'b0;
            end else begin
              bump_cell(x, y, int'(miss_inc));
              r.count = r.count + 1'b1;
              e2 = 2 * err;
              if (e2 > -dy) begin
                err -= dy;
                x += sx;
              end
              if (e2 < dx) begin
                err += dx;
                y += sy;
              end
              // walk stopped before the new cell once it runs too far
              if (((x > x0) ? x - x0 : x0 - x) > DEF_STEP_LIMIT ||
                  ((y > y0) ? y - y0 : y0 - y) > DEF_STEP_LIMIT) begin
                r.status = STS_TRUNC;
                walking = 1'b0;
              end
            end
          end
        end
      end
      FN_READ: begin
        if (x0 < w && y0 < h) begin
          r.val = mirror_cells[y0 * GRID + x0];
          if (r.val < free_thr)      r.cls = CLS_FREE;
          else if (r.val > occ_thr)  r.cls = CLS_OCC;
          else                       r.cls = CLS_UNKNOWN;
        end else begin
          r.cls = CLS_UNKNOWN;
        end
      end
      FN_CLEAR: begin
        zero_mirror();
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // one input transaction, then burst pacing; entered and left at a falling edge
  task automatic send_op(func_t op, logic [COORD_W-1:0] x0, logic [COORD_W-1:0] y0,
                         logic [COORD_W-1:0] x1, logic [COORD_W-1:0] y1);
    cell_report_t r;
    s_tdata  = {y1, x1, y0, x0};
    s_tuser  = op;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    r = apply_grid_op(op, int'(x0), int'(y0), int'(x1), int'(y1));
    awaited_reports.push_back(r);
    n_ops++;
    if (op == FN_RAY) n_rays++;
    if (op == FN_READ) n_reads++;
    if (op == FN_CLEAR) n_clears++;
    if (r.status == STS_REJECTED) n_rejected++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      if (gaps_on) begin
        s_tvalid = 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      burst_left = $urandom_range(0, 15);
    end
  endtask

  // hold the sender until every awaited report has come back
  task automatic wait_results();
    s_tvalid = 1'b0;
    while (awaited_reports.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
    cfg_index = idx;
    cfg_data  = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_HIT_INC:  hit_inc    = value;
      CFG_MISS_INC: miss_inc   = value;
      CFG_CLAMP_LO: clamp_lo   = value;
      CFG_CLAMP_HI: clamp_hi   = value;
      CFG_WIDTH:    width_reg  = value[DIM_W-1:0];
      CFG_HEIGHT:   height_reg = value[DIM_W-1:0];
      CFG_FREE_THR: free_thr   = value;
      CFG_OCC_THR:  occ_thr    = value;
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_config(logic [CFG_W-1:0] hit, logic [CFG_W-1:0] miss,
                             logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi,
                             logic [CFG_W-1:0] w, logic [CFG_W-1:0] h,
                             logic [CFG_W-1:0] fthr, logic [CFG_W-1:0] othr);
    write_reg(CFG_HIT_INC, hit);
    write_reg(CFG_MISS_INC, miss);
    write_reg(CFG_CLAMP_LO, lo);
    write_reg(CFG_CLAMP_HI, hi);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_FREE_THR, fthr);
    write_reg(CFG_OCC_THR, othr);
  endtask

  // coordinate mostly near a hot spot, sometimes anywhere in use, rarely anywhere
  function automatic logic [COORD_W-1:0] pick_coord(int lim, int hot);
    int v;
    if (lim == 0) return COORD_W'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0:       v = $urandom_range(0, 255);
      1, 2:    v = $urandom_range(0, lim - 1);
      default: begin
        v = hot + $urandom_range(0, 15);
        if (v >= lim) v = $urandom_range(0, lim - 1);
      end
    endcase
    return COORD_W'(v);
  endfunction

  // receiver: picks a new stall pattern (always ready, random, mostly stalled) at random intervals
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    case (rx_mode)
      0:       m_tready = 1'b1;
      1:       m_tready = $urandom_range(0, 1);
      default: m_tready = ($urandom_range(0, 7) == 0);
    endcase
  end

  // compare each result transaction with the oldest awaited report
  always @(posedge clk) begin : report_check
    cell_report_t            want;
    logic [STATUS_W-1:0]     got_status;
    logic [COUNT_W-1:0]      got_count;
    logic signed [VAL_W-1:0] got_val;
    logic [CLASS_W-1:0]      got_cls;
    logic [M_TDATA_W-PAD_LSB-1:0] got_pad;
    if (!rst && m_tvalid && m_tready) begin
      got_status = m_tdata[0 +: STATUS_W];
      got_count  = m_tdata[CNT_LSB +: COUNT_W];
      got_val    = m_tdata[VAL_LSB +: VAL_W];
      got_cls    = m_tdata[CLS_LSB +: CLASS_W];
      got_pad    = m_tdata[M_TDATA_W-1:PAD_LSB];
      if (awaited_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MAX)
          $display("%0t: result with none awaited: status %0d count %0d value %0d class %0d",
                   $realtime, got_status, got_count, got_val, got_cls);
      end else begin
        want = awaited_reports.pop_front();
        reports_checked++;
        if (got_status !== want.status || got_count !== want.count ||
            got_val !== want.val || got_cls !== want.cls || got_pad !== '0) begin
          mismatches++;
          if (mismatches <= SHOWN_MAX)
            $display("%0t: mismatch: want status %0d count %0d value %0d class %0d, %s",
                     $realtime, want.status, want.count, want.val, want.cls,
                     $sformatf("got status %0d count %0d value %0d class %0d fill %0h",
                               got_status, got_count, got_val, got_cls, got_pad));
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports outstanding",
               cycles, awaited_reports.size());
      $display("FAIL");
      $finish;
    end
  end

  // horizontal, vertical, diagonal and shallow lines, single cell, lines spanning the full grid
  task automatic test_directed_rays();
    send_op(FN_READ, 8'd0, 8'd0, 8'd0, 8'd0);
    send_op(FN_RAY, 8'd3, 8'd3, 8'd3, 8'd3);
    send_op(FN_RAY, 8'd0, 8'd10, 8'd255, 8'd10);
    send_op(FN_RAY, 8'd200, 8'd255, 8'd200, 8'd0);
    send_op(FN_RAY, 8'd255, 8'd255, 8'd0, 8'd0);
    send_op(FN_RAY, 8'd90, 8'd60, 8'd20, 8'd57);
    send_op(FN_READ, 8'd255, 8'd10, 8'd0, 8'd0);
  endtask

  // repeated hits run into the upper clamp, then classify
  task automatic test_clamp_and_class();
    repeat (5) send_op(FN_RAY, 8'd50, 8'd50, 8'd50, 8'd50);
    send_op(FN_READ, 8'd50, 8'd50, 8'd255, 8'd255);
  endtask

  task automatic test_clear_and_unused();
    send_op(FN_NONE, 8'd255, 8'd255, 8'd255, 8'd255);
    send_op(FN_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0);
    send_op(FN_READ, 8'd50, 8'd50, 8'd0, 8'd0);
  endtask

  // narrow grid, zero size, oversized registers; cells keep their address
  task automatic test_grid_bounds();
    wait_results();
    write_reg(CFG_WIDTH, CFG_W'(20));
    write_reg(CFG_HEIGHT, CFG_W'(1));
    send_op(FN_RAY, 8'd0, 8'd0, 8'd19, 8'd0);
    send_op(FN_RAY, 8'd0, 8'd0, 8'd20, 8'd0);
    send_op(FN_RAY, 8'd3, 8'd1, 8'd0, 8'd0);
    send_op(FN_READ, 8'd5, 8'd1, 8'd0, 8'd0);
    wait_results();
    write_reg(CFG_WIDTH, CFG_W'(0));
    send_op(FN_RAY, 8'd0, 8'd0, 8'd0, 8'd0);
    wait_results();
    write_reg(CFG_WIDTH, CFG_W'(511));
    write_reg(CFG_HEIGHT, CFG_W'(300));
    send_op(FN_RAY, 8'd255, 8'd255, 8'd250, 8'd255);
    send_op(FN_READ, 8'd19, 8'd0, 8'd0, 8'd0);
  endtask

  // full-scale increments and thresholds, then crossed clamp bounds
  task automatic test_register_extremes();
    wait_results();
    load_config(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
                CFG_W'(GRID), CFG_W'(GRID), 16'h8000, 16'h7FFF);
    send_op(FN_RAY, 8'd1, 8'd1, 8'd3, 8'd1);
    send_op(FN_READ, 8'd1, 8'd1, 8'd0, 8'd0);
    wait_results();
    load_config(CFG_W'(RST_HIT_INC), CFG_W'(RST_MISS_INC), CFG_W'(500), CFG_W'(-500),
                CFG_W'(GRID), CFG_W'(GRID), 16'h7FFF, 16'h8000);
    send_op(FN_RAY, 8'd3, 8'd1, 8'd3, 8'd1);
    send_op(FN_READ, 8'd3, 8'd1, 8'd0, 8'd0);
    send_op(FN_READ, 8'd3, 8'd1, 8'd0, 8'd0);
  endtask

  // random operations over several register settings
  task automatic test_random_traffic();
    int    lim_x, lim_y, hot_x, hot_y, sel;
    func_t op;
    logic [COORD_W-1:0] ax, ay, bx, by;
    for (int phase = 0; phase < 4; phase++) begin
      wait_results();
      case (phase)
        0: load_config(CFG_W'(RST_HIT_INC), CFG_W'(RST_MISS_INC), CFG_W'(RST_CLAMP_LO),
                       CFG_W'(RST_CLAMP_HI), CFG_W'(RST_WIDTH), CFG_W'(RST_HEIGHT),
                       CFG_W'(RST_FREE_THR), CFG_W'(RST_OCC_THR));
        1: load_config(CFG_W'($urandom_range(0, 600)), CFG_W'(-$urandom_range(1, 400)),
                       CFG_W'(-$urandom_range(256, 4096)), CFG_W'($urandom_range(256, 4096)),
                       CFG_W'($urandom_range(8, 64)), CFG_W'($urandom_range(8, 64)),
                       CFG_W'(-$urandom_range(0, 600)), CFG_W'($urandom_range(0, 600)));
        2: load_config(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                       CFG_W'($urandom), CFG_W'($urandom_range(1, 300)),
                       CFG_W'($urandom_range(1, 300)), CFG_W'($urandom), CFG_W'($urandom));
        default: load_config(($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000,
                             ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000,
                             16'h8000, 16'h7FFF, CFG_W'(GRID), CFG_W'(GRID),
                             CFG_W'($urandom), CFG_W'($urandom));
      endcase
      gaps_on = (phase != 1);
      lim_x = used_dim(width_reg);
      lim_y = used_dim(height_reg);
      hot_x = (lim_x > 0) ? $urandom_range(0, lim_x - 1) : 0;
      hot_y = (lim_y > 0) ? $urandom_range(0, lim_y - 1) : 0;
      for (int n = 0; n < 210; n++) begin
        sel = $urandom_range(0, 99);
        ax = pick_coord(lim_x, hot_x);
        ay = pick_coord(lim_y, hot_y);
        bx = pick_coord(lim_x, hot_x);
        by = pick_coord(lim_y, hot_y);
        if (phase == 2 && n == 105) op = FN_CLEAR;
        else if (sel < 55)          op = FN_RAY;
        else if (sel < 93)          op = FN_READ;
        else                        op = FN_NONE;
        // loose fields carry random content
        if (op == FN_READ) begin
          bx = COORD_W'($urandom);
          by = COORD_W'($urandom);
        end
        if (op == FN_NONE) begin
          ax = COORD_W'($urandom);
          ay = COORD_W'($urandom);
        end
        send_op(op, ax, ay, bx, by);
        if ($urandom_range(0, 79) == 0) wait_results();
      end
    end
  endtask

  initial begin
    zero_mirror();
    hit_inc    = RST_HIT_INC;
    miss_inc   = RST_MISS_INC;
    clamp_lo   = RST_CLAMP_LO;
    clamp_hi   = RST_CLAMP_HI;
    width_reg  = RST_WIDTH;
    height_reg = RST_HEIGHT;
    free_thr   = RST_FREE_THR;
    occ_thr    = RST_OCC_THR;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_rays();
    test_clamp_and_class();
    test_clear_and_unused();
    test_grid_bounds();
    test_register_extremes();
    test_random_traffic();

    wait_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("covered %0d operations: %0d rays (%0d out of bounds), %0d reads, %0d clears",
             n_ops, n_rays, n_rejected, n_reads, n_clears);
    $display("%0d results checked, %0d mismatches, %0d cycles",
             reports_checked, mismatches, cycles);
    if (mismatches == 0 && awaited_reports.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
